@@ hw/rtl/rmad_pkg.sv @@
// ----------------------------------------------------------------------------
// rmad_pkg
// Shared constants and types of the running median / absolute deviation core.
// ----------------------------------------------------------------------------
package rmad_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned HEAP_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TOT_W      = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] offset;
  } in_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic signed [63:0] min_total;
    logic               full_res;
  } out_t;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_PUSH,
    HOP_REPLACE
  } heap_op_e;

  typedef struct packed {
    heap_op_e           op;
    logic signed [31:0] val;
  } heap_cmd_t;

  typedef struct packed {
    logic               busy;
    logic [CNT_W-1:0]   cnt;
    logic signed [31:0] top;
  } heap_sts_t;

endpackage

@@ hw/rtl/rmad_heap.sv @@
// ----------------------------------------------------------------------------
// rmad_heap
// Binary heap in synchronous memory (one read, one write port): push with
// sift-up, top replacement by sift-down, one level per read-compare-write step.
// ----------------------------------------------------------------------------
module rmad_heap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               is_max_i,
  input  rmad_pkg::heap_cmd_t cmd_i,
  output rmad_pkg::heap_sts_t sts_o
);
  import rmad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DN_L,
    ST_DN_R,
    ST_FIN
  } state_e;

  logic signed [31:0] mem [HEAP_DEPTH];
  logic signed [31:0] rdata_q;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] ldat_q, ldat_d;
  logic signed [31:0] top_q;

  logic               we;
  logic [IDX_W-1:0]   wa, ra;
  logic signed [31:0] wd;

  logic [IDX_W-1:0]   par;
  logic [IDX_W+1:0]   lft, rgt, nl, bidx, n_ext;
  logic               lbest, rbest;
  logic signed [31:0] cand, bval;

  function automatic logic precedes(input logic signed [31:0] x,
                                    input logic signed [31:0] y,
                                    input logic mx);
    precedes = mx ? (x > y) : (x < y);
  endfunction

  function automatic logic [IDX_W-1:0] parent(input logic [IDX_W-1:0] i);
    parent = (i - 1'b1) >> 1;
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    val_d   = val_q;
    ldat_d  = ldat_q;
    we      = 1'b0;
    wa      = idx_q;
    wd      = val_q;
    ra      = '0;
    par     = parent(idx_q);
    n_ext   = (IDX_W+2)'(cnt_q);
    lft     = {1'b0, idx_q, 1'b1};
    rgt     = lft + 1'b1;
    lbest   = precedes(ldat_q, val_q, is_max_i);
    cand    = lbest ? ldat_q : val_q;
    rbest   = (rgt < n_ext) && precedes(rdata_q, cand, is_max_i);
    bidx    = rbest ? rgt : lft;
    bval    = rbest ? rdata_q : ldat_q;
    nl      = {1'b0, bidx[IDX_W-1:0], 1'b1};
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.op == HOP_PUSH) begin
          val_d = cmd_i.val;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == '0) begin
            we = 1'b1;
            wa = '0;
            wd = cmd_i.val;
          end else begin
            idx_d   = cnt_q[IDX_W-1:0];
            ra      = parent(cnt_q[IDX_W-1:0]);
            state_d = ST_UP;
          end
        end else if (cmd_i.op == HOP_REPLACE) begin
          val_d = cmd_i.val;
          idx_d = '0;
          if (cnt_q == CNT_W'(1)) begin
            we = 1'b1;
            wa = '0;
            wd = cmd_i.val;
          end else begin
            ra      = IDX_W'(1);
            state_d = ST_DN_L;
          end
        end
      end
      ST_UP: begin
        we = 1'b1;
        if (precedes(val_q, rdata_q, is_max_i)) begin
          wd    = rdata_q;
          idx_d = par;
          if (par == '0) begin
            state_d = ST_FIN;
          end else begin
            ra = parent(par);
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DN_L: begin
        ldat_d  = rdata_q;
        ra      = rgt[IDX_W-1:0];
        state_d = ST_DN_R;
      end
      ST_DN_R: begin
        we = 1'b1;
        if (!lbest && !rbest) begin
          state_d = ST_IDLE;
        end else begin
          wd    = bval;
          idx_d = bidx[IDX_W-1:0];
          if (nl < n_ext) begin
            ra      = nl[IDX_W-1:0];
            state_d = ST_DN_L;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        we      = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    ldat_q <= ldat_d;
    if (we && wa == '0) begin
      top_q <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.cnt  = cnt_q;
  assign sts_o.top  = top_q;

endmodule

@@ hw/rtl/running_median_abs_deviation_core.sv @@
// ----------------------------------------------------------------------------
// running_median_abs_deviation_core
// Running lower median with minimum total absolute deviation plus offsets.
// ----------------------------------------------------------------------------
// One word in gives one word out: the lower median of all values so far and
// the minimum of sum |x - a_i| plus the offset sum. The lower half sits in a
// max-heap and the upper half in a min-heap, each a memory of (CAPACITY+1)/2
// entries with one read and one write port. Sift-down sets the item time, as
// it reads two children per heap level through the one read port; sift-up
// reads one parent per level and runs in parallel in the other heap. Once
// CAPACITY values are held, items are answered with full_res set and leave
// the state unchanged.
module running_median_abs_deviation_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rmad_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rmad_pkg::out_t out_o
);
  import rmad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_e;

  state_e             state_q;
  in_t                in_q;
  logic               full_q, first_q;
  logic [32:0]        absd_q;
  logic signed [31:0] med_q;
  logic [63:0]        dev_q, off_q;
  logic               ov_q;
  out_t               out_q;

  heap_cmd_t          lo_cmd, up_cmd;
  heap_sts_t          lo_sts, up_sts;

  logic               full_now, eq;
  logic signed [32:0] diff, rise;

  rmad_heap u_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b1),
    .cmd_i    (lo_cmd),
    .sts_o    (lo_sts)
  );

  rmad_heap u_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b0),
    .cmd_i    (up_cmd),
    .sts_o    (up_sts)
  );

  assign full_now = (TOT_W'(lo_sts.cnt) + TOT_W'(up_sts.cnt)) >= TOT_W'(CAPACITY);
  assign eq       = (lo_sts.cnt == up_sts.cnt);
  assign diff     = 33'(med_q) - 33'(in_q.value);
  assign rise     = 33'(lo_sts.top) - 33'(first_q ? in_q.value : med_q);

  always_comb begin
    lo_cmd = '{op: HOP_NONE, val: in_q.value};
    up_cmd = '{op: HOP_NONE, val: in_q.value};
    if (state_q == ST_START && !full_now) begin
      if (eq) begin
        if (up_sts.cnt == '0 || in_q.value <= up_sts.top) begin
          lo_cmd.op = HOP_PUSH;
        end else begin
          up_cmd.op  = HOP_REPLACE;
          lo_cmd.op  = HOP_PUSH;
          lo_cmd.val = up_sts.top;
        end
      end else begin
        if (in_q.value >= lo_sts.top) begin
          up_cmd.op = HOP_PUSH;
        end else begin
          lo_cmd.op  = HOP_REPLACE;
          up_cmd.op  = HOP_PUSH;
          up_cmd.val = lo_sts.top;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      med_q   <= '0;
      dev_q   <= '0;
      off_q   <= '0;
      full_q  <= 1'b0;
      first_q <= 1'b0;
      absd_q  <= '0;
    end else begin
      if (state_q == ST_FIN && (!ov_q || out_ready_i)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_START;
          end
        end
        ST_START: begin
          full_q  <= full_now;
          first_q <= (lo_sts.cnt == '0);
          absd_q  <= diff[32] ? 33'(-diff) : 33'(diff);
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!lo_sts.busy && !up_sts.busy) begin
            if (!full_q) begin
              off_q <= off_q + 64'(in_q.offset);
              dev_q <= dev_q + (first_q ? 64'd0 : 64'(absd_q))
                       - ((rise > 0) ? 64'(rise) : 64'd0);
              med_q <= lo_sts.top;
            end
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!ov_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      in_q <= in_i;
    end
    if (state_q == ST_FIN && (!ov_q || out_ready_i)) begin
      out_q.median    <= med_q;
      out_q.min_total <= dev_q + off_q;
      out_q.full_res  <= full_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_sts.cnt == up_sts.cnt) || (lo_sts.cnt == up_sts.cnt + 1'b1))
    else $error("heap sizes out of balance");

  a_idle_heaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_START) |-> (!lo_sts.busy && !up_sts.busy))
    else $error("heap busy outside of an item");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && full_q) |-> $stable(lo_sts.cnt) && $stable(up_sts.cnt))
    else $error("heap changed on a full item");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TOT_W'(lo_sts.cnt) + TOT_W'(up_sts.cnt)) <= TOT_W'(CAPACITY))
    else $error("store holds more than capacity");

endmodule

@@ tb/running_median_abs_deviation_core_tb.sv @@
// ----------------------------------------------------------------------------
// running_median_abs_deviation_core_tb
// Self-checking bench for the running median / absolute deviation core.
// ----------------------------------------------------------------------------
// Drives value/offset words through a valid/ready handshake, predicts the
// lower median and min total with two behavioral heaps, and compares every
// result word in order. Covers value extremes, fill to capacity (full flag),
// random and clustered values, random idling on both sides and a long
// receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
module running_median_abs_deviation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmad_pkg::*;

  localparam int unsigned LOW_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned UP_DEPTH  = CAPACITY / 2;
  localparam int          NUM_RAND  = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  always #1 clk_i = ~clk_i;

  running_median_abs_deviation_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // predictor state
  logic signed [31:0] max_heap [LOW_DEPTH];
  logic signed [31:0] min_heap [UP_DEPTH];
  int unsigned        n_low, n_up;
  logic signed [31:0] med_q;
  logic [63:0]        dev_sum, off_sum;

  out_t expected_words[$];
  int   n_mismatch = 0;
  int   n_checked = 0;
  int   n_full = 0;
  bit   hold_off = 1'b0;
  bit   calm = 1'b0;

  function automatic bit ahead(logic signed [31:0] x, logic signed [31:0] y, bit is_max);
    return is_max ? (x > y) : (x < y);
  endfunction

  function automatic void heap_push(bit is_max, logic signed [31:0] v);
    int unsigned i, p;
    logic signed [31:0] t;
    i = is_max ? n_low : n_up;
    if (is_max) max_heap[i] = v; else min_heap[i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_max) begin
        if (!ahead(max_heap[i], max_heap[p], 1'b1)) break;
        t = max_heap[i]; max_heap[i] = max_heap[p]; max_heap[p] = t;
      end else begin
        if (!ahead(min_heap[i], min_heap[p], 1'b0)) break;
        t = min_heap[i]; min_heap[i] = min_heap[p]; min_heap[p] = t;
      end
      i = p;
    end
    if (is_max) n_low++; else n_up++;
  endfunction

  function automatic void heap_replace_top(bit is_max, logic signed [31:0] v);
    int unsigned i, l, r, best, n;
    logic signed [31:0] t;
    n = is_max ? n_low : n_up;
    i = 0;
    if (is_max) max_heap[0] = v; else min_heap[0] = v;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (is_max) begin
        if (l < n && max_heap[l] > max_heap[best]) best = l;
        if (r < n && max_heap[r] > max_heap[best]) best = r;
        if (best == i) break;
        t = max_heap[i]; max_heap[i] = max_heap[best]; max_heap[best] = t;
      end else begin
        if (l < n && min_heap[l] < min_heap[best]) best = l;
        if (r < n && min_heap[r] < min_heap[best]) best = r;
        if (best == i) break;
        t = min_heap[i]; min_heap[i] = min_heap[best]; min_heap[best] = t;
      end
      i = best;
    end
  endfunction

  function automatic out_t predict_median(in_t w);
    out_t r;
    bit   first;
    logic signed [31:0] a, prev, cur, top;
    logic signed [63:0] d;
    a = w.value;
    r = '0;
    if (n_low + n_up >= CAPACITY) begin
      r.full_res = 1'b1;
    end else begin
      first = (n_low == 0);
      off_sum += {{32{w.offset[31]}}, w.offset};
      if (!first) begin
        d = 64'(med_q) - 64'(a);
        if (d < 0) d = -d;
        dev_sum += d;
      end
      if (n_low == n_up) begin
        if (n_up == 0 || a <= min_heap[0]) begin
          heap_push(1'b1, a);
        end else begin
          top = min_heap[0];
          heap_replace_top(1'b0, a);
          heap_push(1'b1, top);
        end
      end else begin
        if (a >= max_heap[0]) begin
          heap_push(1'b0, a);
        end else begin
          top = max_heap[0];
          heap_replace_top(1'b1, a);
          heap_push(1'b0, top);
        end
      end
      prev = first ? a : med_q;
      cur = max_heap[0];
      if (prev < cur) dev_sum -= 64'(cur) - 64'(prev);
      med_q = cur;
    end
    r.median = med_q;
    r.min_total = dev_sum + off_sum;
    return r;
  endfunction

  // directed rows: typed expectation where it is obvious
  typedef struct {
    in_t  word;
    bit   typed;
    out_t res;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(logic signed [31:0] v, logic signed [31:0] o,
                              bit typed = 1'b0, logic signed [31:0] m = '0,
                              logic signed [63:0] tot = '0);
    row_t r;
    r.word.value = v;
    r.word.offset = o;
    r.typed = typed;
    r.res.median = m;
    r.res.min_total = tot;
    r.res.full_res = 1'b0;
    return r;
  endfunction

  task automatic send_word(in_t w, bit typed, out_t res);
    out_t p;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    p = predict_median(w);
    if (typed && p != res) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("table row disagrees with predictor: %p vs %p", res, p);
    end
    expected_words.push_back(p);
    in_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(40)) - 20;
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  initial begin
    int mode;
    in_t w;
    rows.push_back(mk(32'sh80000000, 32'sh7fffffff, 1'b1, 32'sh80000000,
                      64'sh7fffffff));
    rows.push_back(mk(32'sh7fffffff, 32'sh80000000, 1'b1, 32'sh80000000,
                      64'sh00000000fffffffe));
    rows.push_back(mk(0, 0));
    rows.push_back(mk(32'sh7fffffff, -1));
    rows.push_back(mk(32'sh80000000, 1));
    rows.push_back(mk(5, 32'sh55555555));
    rows.push_back(mk(5, 32'shaaaaaaaa));
    rows.push_back(mk(-5, 0));
    rows.push_back(mk(32'sh55555555, 3));
    rows.push_back(mk(32'shaaaaaaaa, -3));
    rows.push_back(mk(1, 0));
    rows.push_back(mk(-1, 0));
    n_low = 0; n_up = 0; med_q = '0; dev_sum = '0; off_sum = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].res);
    for (int i = 0; i < NUM_RAND; i++) begin
      calm = (i >= 200 && i < 300);
      mode = $urandom_range(3);
      w.value = rand_value(mode);
      w.offset = ($urandom_range(3) == 0) ? 32'($urandom) : $signed($urandom_range(200)) - 100;
      if (i == 400) hold_off = 1'b1;
      send_word(w, 1'b0, '0);
    end
    // fill to capacity, then probe the full flag
    while (n_low + n_up < CAPACITY) begin
      w.value = $urandom;
      w.offset = $urandom;
      send_word(w, 1'b0, '0);
    end
    for (int i = 0; i < 20; i++) begin
      w.value = $urandom;
      w.offset = $urandom;
      send_word(w, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("checked %0d result words, %0d with the store full; final count %0d",
             n_checked, n_full, n_low + n_up);
    if (n_mismatch == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= calm || ($urandom_range(99) >= 30);
    end
  end

  // checker
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word %p", out_o);
      end else begin
        e = expected_words.pop_front();
        n_checked++;
        if (e.full_res) n_full++;
        if (out_o.median !== e.median || out_o.min_total !== e.min_total ||
            out_o.full_res !== e.full_res) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected med=%0d tot=%0d full=%0b, got med=%0d tot=%0d full=%0b",
                     e.median, e.min_total, e.full_res,
                     out_o.median, out_o.min_total, out_o.full_res);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
